[src/fdem_pkg.sv]
// Package for the FAT directory entry matcher.
// Holds verdict codes, entry layout constants and the name config struct.
// No dependencies.
package fdem_pkg;

  typedef enum logic [1:0] {
    VERDICT_NO_MATCH = 2'd0,
    VERDICT_MATCH    = 2'd1,
    VERDICT_SKIPPED  = 2'd2,
    VERDICT_END      = 2'd3
  } verdict_t;

  typedef logic [4:0] byte_pos_t;

  localparam int unsigned ENTRY_BYTES = 32;
  localparam int unsigned NAME_BYTES  = 11;

  localparam byte_pos_t POS_LEAD   = 5'd0;
  localparam byte_pos_t POS_ATTR   = 5'd11;
  localparam byte_pos_t POS_CLU_HI0 = 5'd20;
  localparam byte_pos_t POS_CLU_HI1 = 5'd21;
  localparam byte_pos_t POS_CLU_LO0 = 5'd26;
  localparam byte_pos_t POS_CLU_LO1 = 5'd27;
  localparam byte_pos_t POS_SIZE0  = 5'd28;
  localparam byte_pos_t POS_SIZE1  = 5'd29;
  localparam byte_pos_t POS_SIZE2  = 5'd30;
  localparam byte_pos_t POS_LAST   = 5'(ENTRY_BYTES - 1);

  localparam logic [7:0] END_MARK     = 8'h00;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] LFN_MASK     = 8'h3F;
  localparam logic [7:0] LFN_ATTR     = 8'h0F;
  localparam logic [7:0] VOLUME_BIT   = 8'h08;
  localparam logic [7:0] CASE_MASK    = 8'hDF;

  localparam logic [63:0] NAME_BASE_RESET = 64'h2020_2020_2020_2020;
  localparam logic [23:0] NAME_EXT_RESET  = 24'h20_2020;

  // Register indexes (byte address / 8)
  localparam logic REG_NAME_BASE = 1'b0;
  localparam logic REG_NAME_EXT  = 1'b1;

  typedef struct packed {
    logic [23:0] name_extension;
    logic [63:0] name_base;
  } name_cfg_t;

endpackage

[src/fdem_if.sv]
// Stream channel interfaces for the FAT directory entry matcher.
// Depends on fdem_pkg for the verdict type.
interface fdem_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_byte;
  logic       new_scan;

  modport source (output valid, entry_byte, new_scan, input ready);
  modport sink   (input valid, entry_byte, new_scan, output ready);
endinterface

interface fdem_out_if;
  logic              valid;
  logic              ready;
  fdem_pkg::verdict_t verdict;
  logic [31:0]       first_cluster;
  logic [31:0]       file_size;

  modport source (output valid, verdict, first_cluster, file_size, input ready);
  modport sink   (input valid, verdict, first_cluster, file_size, output ready);
endinterface

[src/fat_dir_entry_matcher_top.sv]
// FAT32 short-name directory entry matcher: takes one directory byte per cycle, 32 bytes
// per entry, and gives one verdict per entry in the cycle after its last byte is taken. The
// rate is one byte per cycle, set by a single pass of per-byte logic between the entry
// state registers and a one-deep result register; in_ch.ready drops only while a result
// sits in that register and out_ch.ready is low. The target name is written through the
// APB port: padded name bytes 0..7 at address 0x0, extension bytes at 0x8.
// Depends on fdem_pkg, fdem_if and fdem_cfg_regs.
module fat_dir_entry_matcher_top (
  input  logic              clk,
  input  logic              rst_n,
  fdem_in_if.sink           in_ch,
  fdem_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  fdem_pkg::name_cfg_t name_cfg;

  fdem_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .name_cfg (name_cfg)
  );

  assign cfg_pready = 1'b1;

  // Entry state
  fdem_pkg::byte_pos_t pos_r, pos_nxt;
  logic        names_eq_r, names_eq_nxt;
  logic        ended_r, ended_nxt;
  logic [7:0]  lead_r;
  logic [7:0]  attr_r;
  logic [31:0] cluster_r;
  logic [23:0] size_r;

  // Result register
  logic               out_valid_r;
  fdem_pkg::verdict_t verdict_r, verdict_nxt;
  logic [31:0]        cluster_out_r;
  logic [31:0]        size_out_r;

  logic                in_acc;
  fdem_pkg::byte_pos_t pos_eff;
  logic                names_eq_eff;
  logic                ended_eff;
  logic [87:0]         name_vec;
  logic [7:0]          name_byte;
  logic                byte_eq;
  logic                last_byte;
  logic [7:0]          b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.entry_byte;

  // A new scan drops the partial entry and restarts at byte 0
  assign pos_eff      = in_ch.new_scan ? fdem_pkg::POS_LEAD : pos_r;
  assign ended_eff    = in_ch.new_scan ? 1'b0 : ended_r;
  assign names_eq_eff = (pos_eff == fdem_pkg::POS_LEAD) ? 1'b1 : names_eq_r;

  assign name_vec  = {name_cfg.name_extension, name_cfg.name_base};
  assign name_byte = name_vec[8 * pos_eff[3:0] +: 8];
  assign byte_eq   = (b & fdem_pkg::CASE_MASK) == (name_byte & fdem_pkg::CASE_MASK);
  assign last_byte = (pos_eff == fdem_pkg::POS_LAST);

  always_comb begin
    names_eq_nxt = names_eq_eff;
    if (pos_eff < fdem_pkg::byte_pos_t'(fdem_pkg::NAME_BYTES)) begin
      names_eq_nxt = names_eq_eff && byte_eq;
    end
    pos_nxt = pos_eff + 5'd1;
    ended_nxt = ended_eff;
    verdict_nxt = fdem_pkg::VERDICT_NO_MATCH;
    if (ended_eff || lead_r == fdem_pkg::END_MARK) begin
      verdict_nxt = fdem_pkg::VERDICT_END;
    end else if (lead_r == fdem_pkg::DELETED_MARK) begin
      verdict_nxt = fdem_pkg::VERDICT_SKIPPED;
    end else if ((attr_r & fdem_pkg::LFN_MASK) == fdem_pkg::LFN_ATTR) begin
      verdict_nxt = fdem_pkg::VERDICT_SKIPPED;
    end else if ((attr_r & fdem_pkg::VOLUME_BIT) != 8'd0) begin
      verdict_nxt = fdem_pkg::VERDICT_SKIPPED;
    end else if (names_eq_r) begin
      verdict_nxt = fdem_pkg::VERDICT_MATCH;
    end
    if (last_byte && verdict_nxt == fdem_pkg::VERDICT_END) begin
      ended_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= fdem_pkg::POS_LEAD;
      names_eq_r <= 1'b1;
      ended_r    <= 1'b0;
    end else if (in_acc) begin
      pos_r      <= pos_nxt;
      names_eq_r <= names_eq_nxt;
      ended_r    <= ended_nxt;
    end
  end

  // Field capture; every field is rewritten before the last byte of its entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (pos_eff)
        fdem_pkg::POS_LEAD:    lead_r           <= b;
        fdem_pkg::POS_ATTR:    attr_r           <= b;
        fdem_pkg::POS_CLU_HI0: cluster_r[23:16] <= b;
        fdem_pkg::POS_CLU_HI1: cluster_r[31:24] <= b;
        fdem_pkg::POS_CLU_LO0: cluster_r[7:0]   <= b;
        fdem_pkg::POS_CLU_LO1: cluster_r[15:8]  <= b;
        fdem_pkg::POS_SIZE0:   size_r[7:0]      <= b;
        fdem_pkg::POS_SIZE1:   size_r[15:8]     <= b;
        fdem_pkg::POS_SIZE2:   size_r[23:16]    <= b;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_byte) begin
      verdict_r <= verdict_nxt;
      if (verdict_nxt == fdem_pkg::VERDICT_MATCH) begin
        cluster_out_r <= cluster_r;
        size_out_r    <= {b, size_r};
      end else begin
        cluster_out_r <= 32'd0;
        size_out_r    <= 32'd0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.verdict       = verdict_r;
  assign out_ch.first_cluster = cluster_out_r;
  assign out_ch.file_size     = size_out_r;

  a_last_byte_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_acc && last_byte) |=> out_ch.valid
  ) else $error("last entry byte taken without a result");

  a_no_result_midentry: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_acc && !last_byte && out_ch.ready) |=> !out_ch.valid
  ) else $error("result produced without a completed entry");

  a_ended_stays_end: assert property (
    @(posedge clk) disable iff (!rst_n)
    (ended_r && in_acc && !in_ch.new_scan && last_byte) |=>
      (out_ch.verdict == fdem_pkg::VERDICT_END)
  ) else $error("entry after end of directory not reported as end");

  a_fields_zero_unless_match: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.verdict != fdem_pkg::VERDICT_MATCH) |->
      (out_ch.first_cluster == 32'd0 && out_ch.file_size == 32'd0)
  ) else $error("cluster or size nonzero on a non-match verdict");

endmodule

[src/fdem_cfg_regs.sv]
// APB-style configuration registers holding the padded 8.3 target name.
// Depends on fdem_pkg for reset values, register indexes and name_cfg_t.
module fdem_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output fdem_pkg::name_cfg_t name_cfg
);

  logic [63:0] name_base_r;
  logic [23:0] name_ext_r;
  logic        wr_en;
  logic        reg_idx;

  assign reg_idx = paddr[3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_base_r <= fdem_pkg::NAME_BASE_RESET;
      name_ext_r  <= fdem_pkg::NAME_EXT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        fdem_pkg::REG_NAME_BASE: name_base_r <= pwdata;
        fdem_pkg::REG_NAME_EXT:  name_ext_r  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fdem_pkg::REG_NAME_BASE: prdata = name_base_r;
      fdem_pkg::REG_NAME_EXT:  prdata = {40'd0, name_ext_r};
      default:                 prdata = 64'd0;
    endcase
  end

  assign name_cfg.name_base      = name_base_r;
  assign name_cfg.name_extension = name_ext_r;

endmodule

[sim/testbench.sv]
// Testbench for fat_dir_entry_matcher_top: streams FAT32 directory entries byte by byte,
// predicts the verdict of each entry and checks every result transaction against it.
// Depends on fdem_pkg, fdem_if and the RTL under src.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    fdem_pkg::verdict_t verdict;
    logic [31:0]        cluster;
    logic [31:0]        size;
  } dir_verdict_t;

  typedef struct packed {
    logic        fresh;
    logic [87:0] short_name;
    logic [7:0]  attr;
    logic [31:0] cluster;
    logic [31:0] size;
  } dir_entry_t;

  // One row of the directed table: either a target name write or a run of entry bytes
  typedef struct packed {
    bit                 wr_target;
    dir_entry_t         ent;
    logic [5:0]         from;
    logic [5:0]         upto;
    bit                 typed;
    fdem_pkg::verdict_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  fdem_in_if  in_ch ();
  fdem_out_if out_ch ();

  fat_dir_entry_matcher_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Scanner state mirrored by the predictor
  fdem_pkg::byte_pos_t scan_pos;
  logic        scan_names_eq;
  logic [7:0]  scan_lead;
  logic [7:0]  scan_attr;
  logic [31:0] scan_cluster;
  logic [31:0] scan_size;
  logic        scan_ended;
  logic [63:0] tgt_base;
  logic [23:0] tgt_ext;

  dir_verdict_t verdicts_due[$];
  dir_row_t     plan[$];
  int           mismatches = 0;
  int           verdicts_seen = 0;
  int           bytes_sent = 0;
  bit           calm = 0;
  bit           long_hold = 0;
  bit           typed_on = 0;
  dir_verdict_t typed_want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function void drop_entry();
    scan_pos      = '0;
    scan_names_eq = 1'b1;
    scan_lead     = '0;
    scan_attr     = '0;
    scan_cluster  = '0;
    scan_size     = '0;
  endfunction

  // Advance the scanner by one byte; return 1 when the byte closes an entry
  function bit scan_byte(input logic [7:0] b, input logic new_scan,
                         output dir_verdict_t res);
    logic [7:0]         tgt;
    fdem_pkg::verdict_t v;
    res = '0;
    if (new_scan) begin
      drop_entry();
      scan_ended = 1'b0;
    end
    if (scan_pos == fdem_pkg::POS_LEAD) scan_lead = b;
    if (scan_pos == fdem_pkg::POS_ATTR) scan_attr = b;
    if (scan_pos < fdem_pkg::NAME_BYTES) begin
      tgt = (scan_pos < 8) ? tgt_base[8*scan_pos +: 8] : tgt_ext[8*(scan_pos-8) +: 8];
      if ((b & fdem_pkg::CASE_MASK) != (tgt & fdem_pkg::CASE_MASK)) scan_names_eq = 1'b0;
    end
    case (scan_pos)
      fdem_pkg::POS_CLU_HI0: scan_cluster[23:16] = b;
      fdem_pkg::POS_CLU_HI1: scan_cluster[31:24] = b;
      fdem_pkg::POS_CLU_LO0: scan_cluster[7:0]   = b;
      fdem_pkg::POS_CLU_LO1: scan_cluster[15:8]  = b;
      fdem_pkg::POS_SIZE0:   scan_size[7:0]      = b;
      fdem_pkg::POS_SIZE1:   scan_size[15:8]     = b;
      fdem_pkg::POS_SIZE2:   scan_size[23:16]    = b;
      fdem_pkg::POS_LAST:    scan_size[31:24]    = b;
      default: ;
    endcase
    if (scan_pos != fdem_pkg::POS_LAST) begin
      scan_pos = scan_pos + 1'b1;
      return 1'b0;
    end
    // End wins over every other test, then the deleted mark, long name, volume label
    if (scan_ended || scan_lead == fdem_pkg::END_MARK) begin
      scan_ended = 1'b1;
      v = fdem_pkg::VERDICT_END;
    end else if (scan_lead == fdem_pkg::DELETED_MARK) begin
      v = fdem_pkg::VERDICT_SKIPPED;
    end else if ((scan_attr & fdem_pkg::LFN_MASK) == fdem_pkg::LFN_ATTR) begin
      v = fdem_pkg::VERDICT_SKIPPED;
    end else if ((scan_attr & fdem_pkg::VOLUME_BIT) != 0) begin
      v = fdem_pkg::VERDICT_SKIPPED;
    end else if (scan_names_eq) begin
      v = fdem_pkg::VERDICT_MATCH;
    end else begin
      v = fdem_pkg::VERDICT_NO_MATCH;
    end
    res.verdict = v;
    res.cluster = (v == fdem_pkg::VERDICT_MATCH) ? scan_cluster : 32'd0;
    res.size    = (v == fdem_pkg::VERDICT_MATCH) ? scan_size : 32'd0;
    drop_entry();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    dir_verdict_t due;
    dir_verdict_t res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_ch.verdict), 32'd0);
        end else begin
          due = verdicts_due.pop_front();
          if (out_ch.verdict != due.verdict)
            report_mismatch("verdict", 32'(out_ch.verdict), 32'(due.verdict));
          if (out_ch.first_cluster != due.cluster)
            report_mismatch("first_cluster", out_ch.first_cluster, due.cluster);
          if (out_ch.file_size != due.size)
            report_mismatch("file_size", out_ch.file_size, due.size);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (scan_byte(in_ch.entry_byte, in_ch.new_scan, res))
          verdicts_due.push_back(typed_on ? typed_want : res);
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none once calm
  initial begin
    int hold;
    int run;
    bit hold_done;
    hold = 0;
    run = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        hold = 200;
        run = 0;
      end
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (calm || run > 0) begin
        out_ch.ready = 1'b1;
        if (run > 0) run--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ch.ready = 1'b0;
        hold = $urandom_range(0, 15);
      end else begin
        out_ch.ready = 1'b1;
        run = $urandom_range(0, 40);
      end
    end
  end

  function automatic logic [87:0] name11(input string s);
    logic [87:0] n;
    for (int i = 0; i < fdem_pkg::NAME_BYTES; i++)
      n[8*i +: 8] = (i < s.len()) ? s[i] : 8'h20;
    return n;
  endfunction

  function automatic logic [7:0] dir_byte(input dir_entry_t e, input int p);
    fdem_pkg::byte_pos_t bp;
    bp = fdem_pkg::byte_pos_t'(p);
    if (p < fdem_pkg::NAME_BYTES) return e.short_name[8*p +: 8];
    case (bp)
      fdem_pkg::POS_ATTR:    return e.attr;
      fdem_pkg::POS_CLU_HI0: return e.cluster[23:16];
      fdem_pkg::POS_CLU_HI1: return e.cluster[31:24];
      fdem_pkg::POS_CLU_LO0: return e.cluster[7:0];
      fdem_pkg::POS_CLU_LO1: return e.cluster[15:8];
      fdem_pkg::POS_SIZE0:   return e.size[7:0];
      fdem_pkg::POS_SIZE1:   return e.size[15:8];
      fdem_pkg::POS_SIZE2:   return e.size[23:16];
      fdem_pkg::POS_LAST:    return e.size[31:24];
      default:               return 8'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic new_scan);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.entry_byte = b;
    in_ch.new_scan   = new_scan;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_entry(input dir_entry_t e, input int from, input int upto);
    for (int p = from; p < upto; p++)
      send_byte(dir_byte(e, p), e.fresh && p == 0);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Drain outstanding verdicts, let the result register settle, then load a new target
  task automatic write_target(input logic [87:0] nm);
    in_ch.valid = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_write({fdem_pkg::REG_NAME_BASE, 3'b000}, nm[63:0]);
    tgt_base = nm[63:0];
    apb_write({fdem_pkg::REG_NAME_EXT, 3'b000}, {40'd0, nm[87:64]});
    tgt_ext = nm[87:64];
  endtask

  task automatic add_row(input bit wr, input logic fresh, input logic [87:0] nm,
                         input logic [7:0] attr, input logic [31:0] clu,
                         input logic [31:0] sz, input int from, input int upto,
                         input bit typed, input fdem_pkg::verdict_t want);
    dir_row_t r;
    r.wr_target = wr;
    r.ent       = '{fresh, nm, attr, clu, sz};
    r.from      = 6'(from);
    r.upto      = 6'(upto);
    r.typed     = typed;
    r.want      = want;
    plan.push_back(r);
  endtask

  initial begin
    logic [87:0] nm;
    logic [95:0] rnd;
    dir_row_t    r;
    dir_entry_t  e;
    int          upto;
    int          since_cfg;
    int          next_cfg;
    int          entries;
    int          base_bytes;
    bit          realign;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.entry_byte = '0;
    in_ch.new_scan = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tgt_base = fdem_pkg::NAME_BASE_RESET;
    tgt_ext = fdem_pkg::NAME_EXT_RESET;
    drop_entry();
    scan_ended = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset target is all spaces; no new_scan on the very first entry
    add_row(0, 0, name11(""), 8'h20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32, 1,
            fdem_pkg::VERDICT_MATCH);
    add_row(0, 0, name11("A"), 8'h00, 32'h1234, 32'd5, 0, 32, 1,
            fdem_pkg::VERDICT_NO_MATCH);
    add_row(1, 0, name11("README  TXT"), 0, 0, 0, 0, 0, 0, fdem_pkg::VERDICT_NO_MATCH);
    add_row(0, 1, name11("readme  txt"), 8'h20, 32'd0, 32'd0, 0, 32, 1,
            fdem_pkg::VERDICT_MATCH);
    add_row(0, 0, name11("README  TXT"), 8'h01, 32'h0001_2345, 32'h1000, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);
    nm = name11("README  TXT");
    nm[7:0] = fdem_pkg::DELETED_MARK;
    add_row(0, 0, nm, 8'h20, 32'd7, 32'd7, 0, 32, 1, fdem_pkg::VERDICT_SKIPPED);
    add_row(0, 0, name11("README  TXT"), 8'h0F, 32'd1, 32'd1, 0, 32, 1,
            fdem_pkg::VERDICT_SKIPPED);
    add_row(0, 0, name11("README  TXT"), 8'hCF, 32'd1, 32'd1, 0, 32, 1,
            fdem_pkg::VERDICT_SKIPPED);
    add_row(0, 0, name11("README  TXT"), 8'h08, 32'd1, 32'd1, 0, 32, 1,
            fdem_pkg::VERDICT_SKIPPED);
    add_row(0, 0, name11("README  TXT"), 8'hFF, 32'd1, 32'd1, 0, 32, 1,
            fdem_pkg::VERDICT_SKIPPED);
    add_row(0, 0, name11("README  TXT"), 8'hF7, 32'h89AB_CDEF, 32'h7F, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);
    add_row(0, 0, name11("README  TXU"), 8'h20, 32'd3, 32'd3, 0, 32, 1,
            fdem_pkg::VERDICT_NO_MATCH);
    // Abandon an entry halfway, then restart the scan
    add_row(0, 0, name11("README  TXT"), 8'h20, 32'd3, 32'd3, 0, 15, 0,
            fdem_pkg::VERDICT_NO_MATCH);
    add_row(0, 1, name11("README  TXT"), 8'h10, 32'hDEAD_0001, 32'd0, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);
    // Swap the target between bytes 5 and 6 of one entry
    add_row(0, 0, name11("README  DOC"), 8'h20, 32'd2, 32'd2, 0, 6, 0,
            fdem_pkg::VERDICT_NO_MATCH);
    add_row(1, 0, name11("README  DOC"), 0, 0, 0, 0, 0, 0, fdem_pkg::VERDICT_NO_MATCH);
    add_row(0, 0, name11("README  DOC"), 8'h20, 32'd2, 32'd2, 6, 32, 0,
            fdem_pkg::VERDICT_NO_MATCH);
    // End marker beats the long-name pattern, and sticks until a new scan
    nm = name11("README  DOC");
    nm[7:0] = fdem_pkg::END_MARK;
    add_row(0, 0, nm, 8'h0F, 32'd9, 32'd9, 0, 32, 1, fdem_pkg::VERDICT_END);
    add_row(0, 0, name11("README  DOC"), 8'h20, 32'd9, 32'd9, 0, 32, 1,
            fdem_pkg::VERDICT_END);
    nm[7:0] = fdem_pkg::DELETED_MARK;
    add_row(0, 0, nm, 8'h08, 32'd9, 32'd9, 0, 32, 1, fdem_pkg::VERDICT_END);
    add_row(0, 0, name11("README  DOC"), 8'h20, 32'd9, 32'd9, 0, 10, 0,
            fdem_pkg::VERDICT_NO_MATCH);
    add_row(0, 1, name11("README  DOC"), 8'h20, 32'hFFFF_0000, 32'h1234_5678, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);
    add_row(1, 0, {88{1'b1}}, 0, 0, 0, 0, 0, 0, fdem_pkg::VERDICT_NO_MATCH);
    add_row(0, 0, {88{1'b1}}, 8'h20, 32'h0102_0304, 32'd0, 0, 32, 1,
            fdem_pkg::VERDICT_MATCH);
    add_row(0, 0, {11{8'hDF}}, 8'h00, 32'hA5A5_5A5A, 32'h8000_0000, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);
    add_row(1, 0, 88'd0, 0, 0, 0, 0, 0, 0, fdem_pkg::VERDICT_NO_MATCH);
    add_row(0, 0, name11(""), 8'h20, 32'd0, 32'hFFFF_FFFF, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);
    add_row(0, 0, {80'd0, 8'h20}, 8'h04, 32'h5555_AAAA, 32'h0F0F_F0F0, 0, 32, 0,
            fdem_pkg::VERDICT_MATCH);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.wr_target) begin
        write_target(r.ent.short_name);
      end else begin
        typed_on = r.typed;
        typed_want.verdict = r.want;
        typed_want.cluster = (r.want == fdem_pkg::VERDICT_MATCH) ? r.ent.cluster : 32'd0;
        typed_want.size    = (r.want == fdem_pkg::VERDICT_MATCH) ? r.ent.size : 32'd0;
        send_entry(r.ent, r.from, r.upto);
      end
    end
    typed_on = 1'b0;

    // Random part: mostly well-formed entries close to the target, some noise
    since_cfg = 0;
    next_cfg = 0;
    entries = 0;
    realign = 1'b1;
    base_bytes = bytes_sent;
    while ((bytes_sent - base_bytes) < 250) begin
      if (bytes_sent - base_bytes > 150) calm = 1'b1;
      if (entries == 2) long_hold = 1'b1;
      if (since_cfg == next_cfg) begin
        rnd = {$urandom, $urandom, $urandom};
        write_target(rnd[87:0]);
        since_cfg = 0;
        next_cfg = $urandom_range(6, 12);
      end
      if ($urandom_range(0, 24) == 0) begin
        repeat ($urandom_range(1, 40))
          send_byte(8'($urandom), $urandom_range(0, 9) == 0);
        realign = 1'b1;
      end else begin
        nm = {tgt_ext, tgt_base};
        case ($urandom_range(0, 3))
          0, 1: for (int i = 0; i < fdem_pkg::NAME_BYTES; i++)
                  nm[8*i + 5] ^= 1'($urandom_range(0, 1));
          2:    nm[8*$urandom_range(0, 10) +: 8] = 8'($urandom);
          default: begin
            rnd = {$urandom, $urandom, $urandom};
            nm = rnd[87:0];
          end
        endcase
        case ($urandom_range(0, 32))
          0, 1: nm[7:0] = fdem_pkg::DELETED_MARK;
          2:    nm[7:0] = fdem_pkg::END_MARK;
          default: ;
        endcase
        e.short_name = nm;
        case ($urandom_range(0, 5))
          0: e.attr = 8'h20;
          1: e.attr = 8'h10;
          2: e.attr = 8'h00;
          3: e.attr = 8'h01;
          default: e.attr = 8'($urandom);
        endcase
        e.cluster = $urandom;
        e.size = $urandom;
        e.fresh = realign || $urandom_range(0, 15) == 0 ||
                  (scan_ended && $urandom_range(0, 1) == 0);
        upto = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 31) : 32;
        realign = (upto != 32);
        send_entry(e, 0, upto);
      end
      entries++;
      since_cfg++;
    end

    in_ch.valid = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[fat_dir_entry_matcher_top.f]
src/fdem_pkg.sv
src/fdem_if.sv
src/fdem_cfg_regs.sv
src/fat_dir_entry_matcher_top.sv
sim/testbench.sv
